### src/rgbh_pkg.sv
`default_nettype none

package rgbh_pkg;

	localparam int ChanW     = 8;
	localparam int HueW      = 16;
	localparam int SatW      = 17;
	localparam int DivisorW  = 11;                 // 6 * chroma reaches 1530
	localparam int RemW      = DivisorW;
	localparam int QuoW      = 16;                 // bits produced by the division stages
	localparam int StepsPerStage = 2;
	localparam int DivStages = QuoW / StepsPerStage;
	localparam int NumW      = 12;                 // signed hue numerator before wrap

	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	typedef struct packed {
		logic [ChanW-1:0]        value;
		logic [ChanW-1:0]        chroma;
		sector_t                 sector;
		logic signed [ChanW:0]   diff;
	} front_t;

	typedef struct packed {
		logic [DivisorW-1:0] divisor;
		logic [RemW-1:0]     rem;
		logic [QuoW-1:0]     quo;
	} div_lane_t;

	typedef struct packed {
		div_lane_t        hue_lane;
		div_lane_t        sat_lane;
		logic             sat_msb;
		logic             sat_zero;
		logic             hue_zero;
		logic [ChanW-1:0] value;
	} work_t;

	// one restoring division step: shift in a zero, subtract when it fits
	function automatic div_lane_t div_step(div_lane_t lane);
		div_lane_t          res;
		logic [RemW:0]      rem2;
		logic [RemW:0]      dvs;
		logic               fits;
		res  = lane;
		rem2 = {lane.rem, 1'b0};
		dvs  = {1'b0, lane.divisor};
		fits = (rem2 >= dvs);
		res.rem = fits ? RemW'(rem2 - dvs) : RemW'(rem2);
		res.quo = {lane.quo[QuoW-2:0], fits};
		return res;
	endfunction

endpackage

`default_nettype wire

### src/rgbh_rgb_if.sv
`default_nettype none

interface rgbh_rgb_if;
	import rgbh_pkg::*;

	logic             valid;
	logic             ready;
	logic [ChanW-1:0] red;
	logic [ChanW-1:0] green;
	logic [ChanW-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

### src/rgbh_hsv_if.sv
`default_nettype none

interface rgbh_hsv_if;
	import rgbh_pkg::*;

	logic             valid;
	logic             ready;
	logic [HueW-1:0]  hue;
	logic [SatW-1:0]  saturation;
	logic [ChanW-1:0] brightness;

	modport source (output valid, output hue, output saturation, output brightness, input ready);
	modport sink (input valid, input hue, input saturation, input brightness, output ready);
endinterface

`default_nettype wire

### src/rgb_to_hsv_converter_unit.sv
`default_nettype none
// Pipeline: 2 front stages, then 8 division stages.
// Throughput: one pixel per cycle while hsv.ready does not stall; the 16-bit quotients are formed two bits per stage.
// Each stage loads whenever it is empty or its content moves on, so bubbles close up.
// Reset: arst_n asynchronously clears all stage valid bits; data registers are not reset.

module rgb_to_hsv_converter_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rgbh_rgb_if.sink   rgb,
	rgbh_hsv_if.source hsv
);
	import rgbh_pkg::*;

	logic   vld_s1;
	front_t front_s1;
	logic   vld_s2;
	work_t  work_s2;

	front_t front_d;
	work_t  work_d;
	logic   rdy_s1;
	logic   rdy_s2;

	logic  stg_valid [DivStages+1];
	logic  stg_ready [DivStages+1];
	work_t stg_data  [DivStages+1];

	// stage 1: largest, smallest, sector and signed difference
	always_comb begin
		logic [ChanW-1:0] mn;
		front_d = '0;
		mn      = rgb.red;
		if (rgb.green < mn) mn = rgb.green;
		if (rgb.blue < mn)  mn = rgb.blue;
		priority if (rgb.red >= rgb.green && rgb.red >= rgb.blue) begin
			front_d.value  = rgb.red;
			front_d.sector = SEC_RED;
			front_d.diff   = $signed({1'b0, rgb.green}) - $signed({1'b0, rgb.blue});
		end else if (rgb.green >= rgb.blue) begin
			front_d.value  = rgb.green;
			front_d.sector = SEC_GREEN;
			front_d.diff   = $signed({1'b0, rgb.blue}) - $signed({1'b0, rgb.red});
		end else begin
			front_d.value  = rgb.blue;
			front_d.sector = SEC_BLUE;
			front_d.diff   = $signed({1'b0, rgb.red}) - $signed({1'b0, rgb.green});
		end
		front_d.chroma = front_d.value - mn;
	end

	// stage 2: hue numerator wrapped into one turn, first saturation bit
	always_comb begin
		logic [DivisorW-1:0]   six_c;
		logic [DivisorW-1:0]   off_c;
		logic signed [NumW-1:0] num;
		logic signed [NumW-1:0] six_cs;
		logic                  sat_hi;
		work_d = '0;
		six_c  = {1'b0, front_s1.chroma, 2'b00} + {2'b00, front_s1.chroma, 1'b0};
		unique case (front_s1.sector)
			SEC_RED:   off_c = '0;
			SEC_GREEN: off_c = {2'b00, front_s1.chroma, 1'b0};
			SEC_BLUE:  off_c = {1'b0, front_s1.chroma, 2'b00};
			default:   off_c = '0;
		endcase
		six_cs = $signed({1'b0, six_c});
		num    = $signed({1'b0, off_c}) + NumW'(front_s1.diff);
		if (num < 0) begin
			num = num + six_cs;
		end else if (num >= six_cs) begin
			num = num - six_cs;
		end
		work_d.hue_lane.divisor = six_c;
		work_d.hue_lane.rem     = RemW'(num);
		work_d.hue_lane.quo     = '0;
		sat_hi = (front_s1.chroma >= front_s1.value);
		work_d.sat_lane.divisor = DivisorW'(front_s1.value);
		work_d.sat_lane.rem     = sat_hi ? '0 : RemW'(front_s1.chroma);
		work_d.sat_lane.quo     = '0;
		work_d.sat_msb  = sat_hi;
		work_d.sat_zero = (front_s1.value == '0);
		work_d.hue_zero = (front_s1.chroma == '0);
		work_d.value    = front_s1.value;
	end

	assign rdy_s2    = !vld_s2 || stg_ready[0];
	assign rdy_s1    = !vld_s1 || rdy_s2;
	assign rgb.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= rgb.valid;
			if (rdy_s2) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && rgb.valid) front_s1 <= front_d;
		if (rdy_s2 && vld_s1)    work_s2  <= work_d;
	end

	assign stg_valid[0] = vld_s2;
	assign stg_data[0]  = work_s2;

	for (genvar k = 0; k < DivStages; k++) begin : g_div
		rgbh_div_stage u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (stg_valid[k]),
			.up_ready (stg_ready[k]),
			.up_data  (stg_data[k]),
			.dn_valid (stg_valid[k+1]),
			.dn_ready (stg_ready[k+1]),
			.dn_data  (stg_data[k+1])
		);
	end

	assign stg_ready[DivStages] = hsv.ready;
	assign hsv.valid      = stg_valid[DivStages];
	assign hsv.hue        = stg_data[DivStages].hue_zero ? '0 : stg_data[DivStages].hue_lane.quo;
	assign hsv.saturation = stg_data[DivStages].sat_zero ? '0 :
		{stg_data[DivStages].sat_msb, stg_data[DivStages].sat_lane.quo};
	assign hsv.brightness = stg_data[DivStages].value;
endmodule

`default_nettype wire

### src/rgbh_div_stage.sv
`default_nettype none

module rgbh_div_stage (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           up_valid,
	output logic                up_ready,
	input  wire rgbh_pkg::work_t up_data,
	output logic                dn_valid,
	input  wire logic           dn_ready,
	output rgbh_pkg::work_t     dn_data
);
	import rgbh_pkg::*;

	logic  vld_q;
	work_t data_q;
	work_t next_data;

	always_comb begin
		next_data = up_data;
		for (int i = 0; i < StepsPerStage; i++) begin
			next_data.hue_lane = div_step(next_data.hue_lane);
			next_data.sat_lane = div_step(next_data.sat_lane);
		end
	end

	// load when empty or when the held transaction leaves this cycle
	assign up_ready = !vld_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (up_ready) begin
			vld_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= next_data;
		end
	end

	assign dn_valid = vld_q;
	assign dn_data  = data_q;
endmodule

`default_nettype wire

### src/rgbh_checker.sv
`default_nettype none

module rgbh_checker (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  out_valid,
	input wire logic                  out_ready,
	input wire logic [rgbh_pkg::HueW-1:0]  hue,
	input wire logic [rgbh_pkg::SatW-1:0]  saturation,
	input wire logic [rgbh_pkg::ChanW-1:0] brightness
);
	import rgbh_pkg::*;

	localparam logic [SatW-1:0] SatOne = SatW'(1) << HueW;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(hue) && $stable(saturation) && $stable(brightness))
		else $error("result changed while stalled");

	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> saturation <= SatOne)
		else $error("saturation above one");

	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && brightness == '0 |-> saturation == '0 && hue == '0)
		else $error("black pixel with nonzero hue or saturation");
endmodule

bind rgb_to_hsv_converter_unit rgbh_checker u_rgbh_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (hsv.valid),
	.out_ready  (hsv.ready),
	.hue        (hsv.hue),
	.saturation (hsv.saturation),
	.brightness (hsv.brightness)
);

`default_nettype wire
